>>> rtl/ebf_pkg.sv
// ----------------------------------------------------------------------------
// ebf_pkg
// Shared constants for the emboss filter: register map, reset values and
// the fixed pixel values of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ebf_pkg;

   // pixel and register widths
   localparam int PIXEL_W  = 8;
   localparam int STRIDE_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = STRIDE_W;

   // width of 3*stride+2 for the largest stride
   localparam int RAW_DLEN_W = STRIDE_W + 2;

   // default delay line size
   localparam int DELAY_DEPTH_DEF = 4096;

   // register reset values
   localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = STRIDE_W'(3);

   // fixed pixel values
   localparam logic [PIXEL_W-1:0] FLAT_VALUE  = PIXEL_W'(128);
   localparam logic [PIXEL_W-1:0] WHITE_VALUE = PIXEL_W'(255);

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_STRIDE  = 2'd0,
      CSR_WHITE_KEEP   = 2'd1,
      CSR_DOUBLE_WIDTH = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

endpackage : ebf_pkg

`default_nettype wire

>>> rtl/ebf_ram.sv
// ----------------------------------------------------------------------------
// ebf_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data, read-first when both ports hit the same address.
// ----------------------------------------------------------------------------
`default_nettype none

module ebf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : ebf_ram

`default_nettype wire

>>> rtl/emboss_bump_filter_unit.sv
// ----------------------------------------------------------------------------
// emboss_bump_filter_unit
// Emboss filter on a raster byte stream: each byte is compared with the byte
// three lines and two pixels back, held in a circular delay line RAM.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_stall | req_pixel_in, req_frame_start
//   rsp     | out       | rsp_valid / rsp_stall | rsp_pixel_out, rsp_last_of_run
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One pixel is taken per cycle while rsp does not stall; in double-width mode
// the single result register sends both copies in turn, stalling input.
// Path from req to rsp_valid: RAM read stage, then the result register.
// Reset is synchronous; it clears pointers, fill count, valids and CSR values.
// The delay line RAM is not cleared.
// A stall on rsp holds the result register, then the input stage, then req.
// ----------------------------------------------------------------------------
`default_nettype none

module emboss_bump_filter_unit
   import ebf_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PIXEL_W-1:0]    req_pixel_in,
   input  wire logic                  req_frame_start,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [PIXEL_W-1:0]    rsp_pixel_out,
   output logic                       rsp_last_of_run,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W  = $clog2(DELAY_DEPTH);
   localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > RAW_DLEN_W) ? FILL_W : RAW_DLEN_W;
   localparam int ADR_W  = FILL_W + 1;

   // configuration registers
   logic [STRIDE_W-1:0] line_stride_ff;
   logic                white_keep_ff;
   logic                double_width_ff;

   // control state
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_flat_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic                out_last_ff, out_last_in;
   logic [PIXEL_W-1:0]  out_pixel_ff, out_pixel_in;

   logic                req_xfer, rsp_xfer, out_free, s1_adv;
   logic [RAW_DLEN_W-1:0] raw_dlen;
   logic [CMP_W-1:0]    raw_dlen_c;
   logic [FILL_W-1:0]   dlen;
   logic [ADR_W-1:0]    wr_ptr_x, dlen_x, rd_sum;
   logic [PTR_W-1:0]    rd_addr;
   logic [FILL_W-1:0]   fill_base;
   logic                flat;
   logic [PIXEL_W-1:0]  delayed;
   logic [PIXEL_W:0]    diff;
   logic [PIXEL_W-1:0]  result;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_stride_ff  <= LINE_STRIDE_RST;
         white_keep_ff   <= 1'b0;
         double_width_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_STRIDE:  line_stride_ff  <= csr_wdata;
            CSR_WHITE_KEEP:   white_keep_ff   <= csr_wdata[0];
            CSR_DOUBLE_WIDTH: double_width_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign rsp_xfer  = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || (rsp_xfer && out_last_ff);
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_xfer  = req_valid && !req_stall;

   // delay length 3*stride+2, saturated at the RAM depth
   always_comb begin
      raw_dlen   = {1'b0, line_stride_ff, 1'b0} + RAW_DLEN_W'(line_stride_ff)
                   + RAW_DLEN_W'(2);
      raw_dlen_c = CMP_W'(raw_dlen);
      if (raw_dlen_c > CMP_W'(DELAY_DEPTH)) begin
         dlen = FILL_W'(DELAY_DEPTH);
      end else begin
         dlen = FILL_W'(raw_dlen_c);
      end
   end

   // read address, dlen places behind the write pointer
   always_comb begin
      wr_ptr_x = ADR_W'(wr_ptr_ff);
      dlen_x   = ADR_W'(dlen);
      if (wr_ptr_x >= dlen_x) begin
         rd_sum = wr_ptr_x - dlen_x;
      end else begin
         rd_sum = wr_ptr_x + ADR_W'(DELAY_DEPTH) - dlen_x;
      end
      rd_addr = rd_sum[PTR_W-1:0];
   end

   // fill count and write pointer
   always_comb begin
      fill_base = req_frame_start ? '0 : fill_ff;
      flat      = fill_base < dlen;
      fill_in   = fill_ff;
      wr_ptr_in = wr_ptr_ff;
      if (req_xfer) begin
         fill_in = flat ? fill_base + FILL_W'(1) : dlen;
         if (wr_ptr_ff == PTR_W'(DELAY_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + PTR_W'(1);
         end
      end
   end

   // delay line
   ebf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_pixel_in),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (delayed)
   );

   // read stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // result: flat value while flat, kept white, else (256 + current - delayed) >> 1
   always_comb begin
      diff = {1'b1, s1_pixel_ff} - {1'b0, delayed};
      if (s1_flat_ff) begin
         result = FLAT_VALUE;
      end else if (white_keep_ff && s1_pixel_ff == WHITE_VALUE) begin
         result = WHITE_VALUE;
      end else begin
         result = diff[PIXEL_W:1];
      end
   end

   // result register, sends the first of a doubled pair then the last
   always_comb begin
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_pixel_in = out_pixel_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
         out_last_in  = !double_width_ff;
         out_pixel_in = result;
      end else if (rsp_xfer) begin
         if (out_last_ff) begin
            out_valid_in = 1'b0;
         end else begin
            out_last_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pixel_ff <= req_pixel_in;
         s1_flat_ff  <= flat;
      end
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_out   = out_pixel_ff;
   assign rsp_last_of_run = out_last_ff;

   // a first-of-pair result only appears in double-width mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> double_width_ff)
      else $error("first of pair outside double-width mode");

   // the second copy of a pair follows with the same pixel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run) |=>
         (rsp_valid && rsp_last_of_run && rsp_pixel_out == $past(rsp_pixel_out)))
      else $error("second copy of pair lost or changed");

   // input is only held back by a waiting read stage
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid))
      else $error("input stalled with nothing in flight");

   // a flat-start pixel gives the flat value
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_flat_ff) |=> (rsp_pixel_out == FLAT_VALUE))
      else $error("flat start result is not the flat value");

endmodule : emboss_bump_filter_unit

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the emboss filter unit. A queue of raster bytes
// feeds a clocked driver that sends in bursts. Every transfer is run through
// a software copy of the delay line, which predicts the embossed bytes. A
// clocked monitor checks each result against the oldest prediction. Register
// settings change only between phases, once all results are back. The
// phases cover the reset setting, small and odd strides, random strides and
// the largest stride.
// ----------------------------------------------------------------------------

module tb_top
   import ebf_pkg::*;
();

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } raster_byte_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } emboss_result_type;

   // clock, reset and block ports
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel_in    = '0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel_out;
   logic                  rsp_last_of_run;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   // predictor state and register copies
   logic [PIXEL_W-1:0]    delay_ram [0:DELAY_DEPTH_DEF-1];
   int unsigned           wr_ptr         = 0;
   int unsigned           frame_fill     = 0;
   logic [STRIDE_W-1:0]   cfg_stride     = LINE_STRIDE_RST;
   logic                  cfg_white_keep = 1'b0;
   logic                  cfg_double     = 1'b0;

   // stimulus and expected results
   raster_byte_type       raster_queue [$];
   emboss_result_type     expected_pixels [$];
   raster_byte_type       next_byte;
   emboss_result_type     want;
   int unsigned           queued_count   = 0;
   int unsigned           accepted_count = 0;
   int unsigned           error_count    = 0;

   // sender and receiver pacing
   int unsigned           burst_left   = 0;
   int unsigned           gap_left     = 0;
   int unsigned           cycle_count  = 0;
   int unsigned           hold_left    = 0;
   int unsigned           stall_mode   = 0;
   logic                  long_hold_done = 1'b0;

   emboss_bump_filter_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // embossed byte(s) for one transferred raster byte
   function automatic void predict_emboss(input logic [PIXEL_W-1:0] cur, input logic restart);
      int unsigned        dlen;
      int unsigned        rd_idx;
      logic [PIXEL_W-1:0] delayed;
      logic [PIXEL_W-1:0] value;
      dlen = 3 * cfg_stride + 2;
      if (dlen > DELAY_DEPTH_DEF) begin
         dlen = DELAY_DEPTH_DEF;
      end
      rd_idx  = (wr_ptr + DELAY_DEPTH_DEF - dlen) % DELAY_DEPTH_DEF;
      delayed = delay_ram[rd_idx];
      if (restart) begin
         frame_fill = 0;
      end
      // flat output until the delay line holds a full window of this frame
      if (frame_fill < dlen) begin
         value = FLAT_VALUE;
         frame_fill++;
      end else begin
         frame_fill = dlen;
         if (cfg_white_keep && cur == WHITE_VALUE) begin
            value = WHITE_VALUE;
         end else begin
            value = PIXEL_W'((256 + int'(cur) - int'(delayed)) >> 1);
         end
      end
      delay_ram[wr_ptr] = cur;
      wr_ptr = (wr_ptr + 1) % DELAY_DEPTH_DEF;
      if (cfg_double) begin
         expected_pixels.push_back('{pixel: value, last: 1'b0});
      end
      expected_pixels.push_back('{pixel: value, last: 1'b1});
   endfunction

   // driver: bursts of random length, random gaps, holds a stalled transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            predict_emboss(req_pixel_in, req_frame_start);
            accepted_count++;
         end
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (raster_queue.size() > 0) begin
            next_byte       = raster_queue.pop_front();
            req_pixel_in    <= next_byte.pixel;
            req_frame_start <= next_byte.frame_start;
            req_valid       <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off while bytes are waiting
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         if (!long_hold_done && cycle_count >= 200 && raster_queue.size() > 8) begin
            hold_left      = 160;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 6);
               default: rsp_stall <= cycle_count[0];
            endcase
         end
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: pixel_out=%0d last_of_run=%0b",
                   rsp_pixel_out, rsp_last_of_run);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               $error("pixel_out: expected %0d, actual %0d", want.pixel, rsp_pixel_out);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last, rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   // one register write; the caller sits on a rising edge
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LINE_STRIDE:  cfg_stride     = data[STRIDE_W-1:0];
         CSR_WHITE_KEEP:   cfg_white_keep = data[0];
         CSR_DOUBLE_WIDTH: cfg_double     = data[0];
         default: ;
      endcase
   endtask

   // all three registers; flag writes carry random upper bits
   task automatic set_mode(input int stride, input bit keep, input bit dbl);
      logic [CSR_DATA_W-1:0] flag_word;
      write_register(CSR_LINE_STRIDE, CSR_DATA_W'(stride));
      flag_word    = CSR_DATA_W'($urandom);
      flag_word[0] = keep;
      write_register(CSR_WHITE_KEEP, flag_word);
      flag_word    = CSR_DATA_W'($urandom);
      flag_word[0] = dbl;
      write_register(CSR_DOUBLE_WIDTH, flag_word);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_byte(input logic [PIXEL_W-1:0] pixel, input logic restart);
      raster_queue.push_back('{pixel: pixel, frame_start: restart});
      queued_count++;
   endtask

   // wait until every byte has gone in and every result has come back
   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_pixels.size() != 0);
   endtask

   // one phase: new setting, then random bytes, extremes weighted up
   task automatic run_phase(input int stride, input bit keep, input bit dbl,
                            input int count, input bit restart_first);
      logic [PIXEL_W-1:0] pixel;
      wait_drained();
      set_mode(stride, keep, dbl);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       pixel = 8'd0;
            1:       pixel = WHITE_VALUE;
            default: pixel = PIXEL_W'($urandom_range(0, 255));
         endcase
         queue_byte(pixel, (i == 0) ? restart_first : ($urandom_range(0, 249) == 0));
      end
   endtask

   initial begin : stimulus
      int  stride;
      int  prev_stride;
      int  dlen;
      bit  restart;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: stride 3 (window 11), white keep and double width on
      write_register(CSR_UNUSED, CSR_DATA_W'($urandom));
      set_mode(3, 1'b1, 1'b1);
      // flat start, white bytes inside it included
      queue_byte(8'd255, 1'b1);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd128, 1'b0);
      queue_byte(8'd1,   1'b0);
      queue_byte(8'd254, 1'b0);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd0,   1'b0);
      // window full: white pass-through, equal bytes, lowest result
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd254, 1'b0);
      queue_byte(8'd255, 1'b0);
      // new frame in mid stream goes flat again
      queue_byte(8'd255, 1'b1);
      queue_byte(8'd17,  1'b0);

      // directed: stride 0 (window 2), plain mode, highest result
      wait_drained();
      set_mode(0, 1'b0, 1'b0);
      queue_byte(8'd0,   1'b1);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd0,   1'b0);
      queue_byte(8'd128, 1'b0);

      // small strides, odd and even, used as given
      run_phase(0, 1'b1, 1'b1, 60, 1'b0);
      run_phase(1, 1'b0, 1'b1, 60, 1'b1);
      run_phase(2, 1'b1, 1'b0, 60, 1'b1);
      prev_stride = 2;

      // random strides; a growing stride always opens a new frame
      for (int p = 0; p < 5; p++) begin
         if ($urandom_range(0, 1) == 0) begin
            stride = $urandom_range(0, 15);
         end else begin
            stride = 2 * $urandom_range(1, 15) + 1;
         end
         restart = (stride > prev_stride) || ($urandom_range(0, 2) == 0);
         dlen    = 3 * stride + 2;
         run_phase(stride, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(40, 70) + (restart ? dlen : 0), restart);
         prev_stride = stride;
      end

      // largest stride while still flat, then shrinking strides within the frame
      run_phase(1023, 1'($urandom_range(0, 1)), 1'b0, 40, 1'b1);
      run_phase(1021, 1'b1, 1'b1, 40, 1'b0);
      run_phase(7, 1'b0, 1'b1, 60, 1'b0);
      run_phase(LINE_STRIDE_RST, 1'b0, 1'b0, 60, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/ebf_pkg.sv
rtl/ebf_ram.sv
rtl/emboss_bump_filter_unit.sv
verif/tb_top.sv
